// ----- design/gcrf_pkg.sv -----
// Package: shared constants and helpers for the geometry coprocessor register file.
`timescale 1ns / 1ps
package gcrf_pkg;
  localparam logic [31:0] FLAG_KEEP_MASK  = 32'h7fff_f000;
  localparam logic [31:0] FLAG_ERROR_MASK = 32'h7f87_e000;
  localparam logic [15:0] COLOR_R_MASK    = 16'h001f;
  localparam logic [15:0] COLOR_G_MASK    = 16'h03e0;
  localparam logic [15:0] COLOR_B_MASK    = 16'h7c00;
  localparam logic [4:0]  LAST_GROUP_REG  = 5'h17;
  localparam logic [5:0]  LEAD_RESET      = 6'd32;

  typedef enum logic {FUNC_READ = 1'b0, FUNC_WRITE = 1'b1} func_t;
  typedef enum logic {BANK_DATA = 1'b0, BANK_CTRL = 1'b1} bank_t;

  typedef struct packed {
    logic        wr;
    logic        ctrl;
    logic [4:0]  idx;
    logic [31:0] data;
  } req_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [4:0] clamp5(input logic [15:0] v);
    logic [8:0] s;
    s = v[15:7];
    if (v[15]) return 5'd0;
    if (s > 9'd31) return 5'd31;
    return s[4:0];
  endfunction
endpackage

// ----- design/geometry_coprocessor_register_file_core.sv -----
// Top level: register file with request register, storage and read result register.
//  channel | valid     | ready     | payload
//  request | req_valid | req_ready | func, bank, reg_index, write_data
//  result  | rsp_valid | rsp_ready | read_data
// One request per cycle unless stalled: input register, then write storage or read to result.
// A write updates storage the cycle after acceptance; a read's result is registered.
// The result register is the only stall point; requests are taken while it can move.
// Synchronous reset clears the valid flags and storage; the leading count resets to 32.
`timescale 1ns / 1ps
module geometry_coprocessor_register_file_core import gcrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        func,
  input  logic        bank,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] read_data
);
  req_t        rq;
  logic        rq_valid;
  logic        advance;
  logic        is_read;
  logic [31:0] rd_val;
  logic [5:0]  lz;

  logic [15:0] vtx [9];
  logic [31:0] color_code, reserved_word, lead_source, flag_word;
  logic [31:0] offset_x, offset_y, depth_coef_b;
  logic [15:0] ordering_z, interp_factor, proj_distance, depth_coef_a;
  logic [15:0] z_scale_three, z_scale_four;
  logic [15:0] iacc [3];
  logic [15:0] sx [3];
  logic [15:0] sy [3];
  logic [15:0] sz [4];
  logic [31:0] cfifo [3];
  logic [31:0] mac [4];
  logic [5:0]  lead_count;
  logic [15:0] mtx [27];
  logic [31:0] cvec [9];

  assign is_read   = rq.wr == FUNC_READ;
  assign advance   = !rq_valid || !is_read || !rsp_valid || rsp_ready;
  assign req_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) rq_valid <= 1'b0;
    else if (advance) rq_valid <= req_valid;
    if (advance) rq <= '{wr: func, ctrl: bank, idx: reg_index, data: write_data};
  end

  gcrf_lzc u_lzc (.value(rq.data), .count(lz));

  always_comb begin
    logic [1:0] g;
    logic [2:0] k;
    g = rq.idx[4:3];
    k = rq.idx[2:0];
    rd_val = '0;
    if (rq.ctrl) begin
      if (rq.idx <= LAST_GROUP_REG) begin
        if (k < 3'd4) rd_val = {mtx[g*9 + k*2 + 1], mtx[g*9 + k*2]};
        else if (k == 3'd4) rd_val = sext16(mtx[g*9 + 8]);
        else rd_val = cvec[g*3 + (k - 3'd5)];
      end else begin
        unique case (rq.idx)
          5'h18: rd_val = offset_x;
          5'h19: rd_val = offset_y;
          5'h1a: rd_val = sext16(proj_distance);
          5'h1b: rd_val = sext16(depth_coef_a);
          5'h1c: rd_val = depth_coef_b;
          5'h1d: rd_val = sext16(z_scale_three);
          5'h1e: rd_val = sext16(z_scale_four);
          default: rd_val = flag_word;
        endcase
      end
    end else begin
      unique case (rq.idx)
        5'd0, 5'd2, 5'd4: rd_val = {vtx[rq.idx[2:1]*3 + 1], vtx[rq.idx[2:1]*3]};
        5'd1, 5'd3, 5'd5: rd_val = sext16(vtx[rq.idx[2:1]*3 + 2]);
        5'd6: rd_val = color_code;
        5'd7: rd_val = {16'd0, ordering_z};
        5'd8: rd_val = sext16(interp_factor);
        5'd9: rd_val = sext16(iacc[0]);
        5'd10: rd_val = sext16(iacc[1]);
        5'd11: rd_val = sext16(iacc[2]);
        5'd12: rd_val = {sy[0], sx[0]};
        5'd13: rd_val = {sy[1], sx[1]};
        5'd14, 5'd15: rd_val = {sy[2], sx[2]};
        5'd16, 5'd17, 5'd18, 5'd19: rd_val = {16'd0, sz[rq.idx[1:0]]};
        5'd20: rd_val = cfifo[0];
        5'd21: rd_val = cfifo[1];
        5'd22: rd_val = cfifo[2];
        5'd23: rd_val = reserved_word;
        5'd24, 5'd25, 5'd26, 5'd27: rd_val = mac[rq.idx[1:0]];
        5'd28, 5'd29: rd_val = {17'd0, clamp5(iacc[2]), clamp5(iacc[1]), clamp5(iacc[0])};
        5'd30: rd_val = lead_source;
        default: rd_val = {26'd0, lead_count};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (advance && rq_valid && is_read) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
    if (advance && rq_valid && is_read) read_data <= rd_val;
  end

  always_ff @(posedge clk) begin
    logic [1:0] g;
    logic [2:0] k;
    logic [15:0] lo, hi;
    g = rq.idx[4:3];
    k = rq.idx[2:0];
    lo = rq.data[15:0];
    hi = rq.data[31:16];
    if (rst) begin
      for (int i = 0; i < 9; i++) begin vtx[i] <= '0; cvec[i] <= '0; end
      for (int i = 0; i < 27; i++) mtx[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        iacc[i] <= '0; sx[i] <= '0; sy[i] <= '0; cfifo[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin sz[i] <= '0; mac[i] <= '0; end
      color_code <= '0; reserved_word <= '0; lead_source <= '0; flag_word <= '0;
      offset_x <= '0; offset_y <= '0; depth_coef_b <= '0;
      ordering_z <= '0; interp_factor <= '0; proj_distance <= '0;
      depth_coef_a <= '0; z_scale_three <= '0; z_scale_four <= '0;
      lead_count <= LEAD_RESET;
    end else if (advance && rq_valid && rq.wr == FUNC_WRITE) begin
      if (rq.ctrl) begin
        if (rq.idx <= LAST_GROUP_REG) begin
          if (k < 3'd4) begin
            mtx[g*9 + k*2] <= lo;
            mtx[g*9 + k*2 + 1] <= hi;
          end else if (k == 3'd4) mtx[g*9 + 8] <= lo;
          else cvec[g*3 + (k - 3'd5)] <= rq.data;
        end else begin
          unique case (rq.idx)
            5'h18: offset_x <= rq.data;
            5'h19: offset_y <= rq.data;
            5'h1a: proj_distance <= lo;
            5'h1b: depth_coef_a <= lo;
            5'h1c: depth_coef_b <= rq.data;
            5'h1d: z_scale_three <= lo;
            5'h1e: z_scale_four <= lo;
            default: flag_word <= (rq.data & FLAG_KEEP_MASK) |
                                  {|(rq.data & FLAG_ERROR_MASK), 31'd0};
          endcase
        end
      end else begin
        unique case (rq.idx)
          5'd0, 5'd2, 5'd4: begin
            vtx[rq.idx[2:1]*3] <= lo;
            vtx[rq.idx[2:1]*3 + 1] <= hi;
          end
          5'd1, 5'd3, 5'd5: vtx[rq.idx[2:1]*3 + 2] <= lo;
          5'd6: color_code <= rq.data;
          5'd7: ordering_z <= lo;
          5'd8: interp_factor <= lo;
          5'd9: iacc[0] <= lo;
          5'd10: iacc[1] <= lo;
          5'd11: iacc[2] <= lo;
          5'd12: begin sx[0] <= lo; sy[0] <= hi; end
          5'd13: begin sx[1] <= lo; sy[1] <= hi; end
          5'd14: begin sx[2] <= lo; sy[2] <= hi; end
          5'd15: begin
            sx[0] <= sx[1]; sx[1] <= sx[2]; sx[2] <= lo;
            sy[0] <= sy[1]; sy[1] <= sy[2]; sy[2] <= hi;
          end
          5'd16, 5'd17, 5'd18, 5'd19: sz[rq.idx[1:0]] <= lo;
          5'd20: cfifo[0] <= rq.data;
          5'd21: cfifo[1] <= rq.data;
          5'd22: cfifo[2] <= rq.data;
          5'd23: reserved_word <= rq.data;
          5'd24, 5'd25, 5'd26, 5'd27: mac[rq.idx[1:0]] <= rq.data;
          5'd28: begin
            iacc[0] <= (lo & COLOR_R_MASK) << 7;
            iacc[1] <= (lo & COLOR_G_MASK) << 2;
            iacc[2] <= (lo & COLOR_B_MASK) >> 3;
          end
          5'd30: begin lead_source <= rq.data; lead_count <= lz; end
          default: ;
        endcase
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data))
    else $error("result changed under stall");
  a_lead_range: assert property (@(posedge clk) disable iff (rst)
    lead_count <= 6'd32) else $error("lead count out of range");
  a_flag_low: assert property (@(posedge clk) disable iff (rst)
    flag_word[11:0] == 12'd0) else $error("flag low bits set");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rq_valid |-> req_ready) else $error("ready low while empty");
endmodule

// ----- design/gcrf_lzc.sv -----
// Leading-ones/zeros counter for the leading-count register.
`timescale 1ns / 1ps
module gcrf_lzc import gcrf_pkg::*; (
  input  logic [31:0] value,
  output logic [5:0]  count
);
  logic [31:0] v;
  always_comb begin
    v = value[31] ? ~value : value;
    count = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) count = 6'(31 - i);
    end
  end
endmodule

// ----- tb/gcrf_checker.sv -----
// Checker: watches both channels, predicts register read results and compares them.
`timescale 1ns / 1ps
module gcrf_checker import gcrf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic        func,
  input  logic        bank,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [31:0] read_data,
  output int          fail_count,
  output int          pending,
  output int          reads_seen,
  output int          writes_seen
);
  logic [15:0] vtx[9];
  logic [31:0] rgbc, ir_word, res_word, lzcs;
  logic [15:0] otz, ir0, ir[3], sx[3], sy[3], sz[4];
  logic [31:0] rgb_fifo[3], mac[4], cvec[9];
  logic [5:0]  lzcr;
  logic [15:0] mtx[27];
  logic [31:0] ofx, ofy, dqb, flag;
  logic [15:0] hdist, dqa, zsf3, zsf4;
  logic [31:0] read_queue[$];

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [4:0] sat5(input logic [15:0] v);
    if (v[15]) return 5'd0;
    if (v[14:7] > 8'd31) return 5'd31;
    return v[11:7];
  endfunction

  function automatic logic [5:0] count_lead(input logic [31:0] v);
    int n;
    n = 0;
    if (v[31]) v = ~v;
    while (n < 32 && !v[31 - n]) n++;
    return n[5:0];
  endfunction

  task automatic clear_state();
    foreach (vtx[i]) vtx[i] = '0;
    foreach (ir[i]) ir[i] = '0;
    foreach (sx[i]) begin sx[i] = '0; sy[i] = '0; rgb_fifo[i] = '0; end
    foreach (sz[i]) begin sz[i] = '0; mac[i] = '0; end
    foreach (mtx[i]) mtx[i] = '0;
    foreach (cvec[i]) cvec[i] = '0;
    rgbc = '0; otz = '0; ir0 = '0; res_word = '0; lzcs = '0; lzcr = LEAD_RESET;
    ofx = '0; ofy = '0; dqb = '0; flag = '0; hdist = '0; dqa = '0; zsf3 = '0; zsf4 = '0;
  endtask

  function automatic logic [31:0] predict_read(input logic ctl, input logic [4:0] n);
    int g, k;
    g = n >> 3;
    k = n & 7;
    if (ctl) begin
      if (n <= LAST_GROUP_REG) begin
        if (k < 4) return {mtx[g*9 + k*2 + 1], mtx[g*9 + k*2]};
        if (k == 4) return ext16(mtx[g*9 + 8]);
        return cvec[g*3 + k - 5];
      end
      case (n)
        24: return ofx;
        25: return ofy;
        26: return ext16(hdist);
        27: return ext16(dqa);
        28: return dqb;
        29: return ext16(zsf3);
        30: return ext16(zsf4);
        default: return flag;
      endcase
    end
    if (n <= 5) begin
      if (!n[0]) return {vtx[(n>>1)*3 + 1], vtx[(n>>1)*3]};
      return ext16(vtx[(n>>1)*3 + 2]);
    end
    case (n)
      6: return rgbc;
      7: return {16'h0, otz};
      8: return ext16(ir0);
      9, 10, 11: return ext16(ir[n - 9]);
      12, 13: return {sy[n - 12], sx[n - 12]};
      14, 15: return {sy[2], sx[2]};
      16, 17, 18, 19: return {16'h0, sz[n - 16]};
      20, 21, 22: return rgb_fifo[n - 20];
      23: return res_word;
      24, 25, 26, 27: return mac[n - 24];
      28, 29: return {17'h0, sat5(ir[2]), sat5(ir[1]), sat5(ir[0])};
      30: return lzcs;
      default: return {26'h0, lzcr};
    endcase
  endfunction

  task automatic apply_write(input logic ctl, input logic [4:0] n, input logic [31:0] v);
    int g, k;
    g = n >> 3;
    k = n & 7;
    if (ctl) begin
      if (n <= LAST_GROUP_REG) begin
        if (k < 4) begin mtx[g*9 + k*2] = v[15:0]; mtx[g*9 + k*2 + 1] = v[31:16]; end
        else if (k == 4) mtx[g*9 + 8] = v[15:0];
        else cvec[g*3 + k - 5] = v;
      end else case (n)
        24: ofx = v;
        25: ofy = v;
        26: hdist = v[15:0];
        27: dqa = v[15:0];
        28: dqb = v;
        29: zsf3 = v[15:0];
        30: zsf4 = v[15:0];
        default: flag = (v & FLAG_KEEP_MASK) | {|(v & FLAG_ERROR_MASK), 31'h0};
      endcase
    end else if (n <= 5) begin
      if (!n[0]) begin vtx[(n>>1)*3] = v[15:0]; vtx[(n>>1)*3 + 1] = v[31:16]; end
      else vtx[(n>>1)*3 + 2] = v[15:0];
    end else case (n)
      6: rgbc = v;
      7: otz = v[15:0];
      8: ir0 = v[15:0];
      9, 10, 11: ir[n - 9] = v[15:0];
      12, 13, 14: begin sx[n - 12] = v[15:0]; sy[n - 12] = v[31:16]; end
      15: begin
        sx[0] = sx[1]; sx[1] = sx[2]; sx[2] = v[15:0];
        sy[0] = sy[1]; sy[1] = sy[2]; sy[2] = v[31:16];
      end
      16, 17, 18, 19: sz[n - 16] = v[15:0];
      20, 21, 22: rgb_fifo[n - 20] = v;
      23: res_word = v;
      24, 25, 26, 27: mac[n - 24] = v;
      28: begin
        ir[0] = {4'h0, v[4:0], 7'h0};
        ir[1] = {4'h0, v[9:5], 7'h0};
        ir[2] = {4'h0, v[14:10], 7'h0};
      end
      30: begin lzcs = v; lzcr = count_lead(v); end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %08h expected %08h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    reads_seen = 0;
    writes_seen = 0;
    pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (read_queue.size() == 0) report_mismatch("unexpected read_data", read_data, '0);
        else begin
          logic [31:0] want;
          want = read_queue.pop_front();
          if (read_data !== want) report_mismatch("read_data", read_data, want);
        end
      end
      if (req_valid && req_ready) begin
        if (func == FUNC_WRITE) begin
          apply_write(bank, reg_index, write_data);
          writes_seen++;
        end else begin
          read_queue.push_back(predict_read(bank, reg_index));
          reads_seen++;
        end
      end
      pending = read_queue.size();
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives register requests, stalls results, and gives the verdict.
`timescale 1ns / 1ps
module tb_top import gcrf_pkg::*;;
  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_ready;
  logic        func = 0;
  logic        bank = 0;
  logic [4:0]  reg_index = 0;
  logic [31:0] write_data = 0;
  logic        rsp_valid;
  logic        rsp_ready = 0;
  logic [31:0] read_data;
  int          fail_count, pending, reads_seen, writes_seen;
  int          cycle_count = 0;
  bit          hold_off = 0;
  bit          hold_done = 0;

  always #2 clk = ~clk;

  geometry_coprocessor_register_file_core DUT (.*);

  gcrf_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall pattern, plus one long hold-off
  initial begin
    int mode;
    @(posedge clk iff !rst);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk);
        if (hold_off) begin
          rsp_ready <= 0;
          repeat (200) @(posedge clk);
          hold_done = 1;
          hold_off = 0;
        end
        case (mode)
          0: rsp_ready <= 1;
          1: rsp_ready <= ($urandom_range(0, 3) != 0);
          default: rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_request(input logic f, input logic b, input logic [4:0] n,
                              input logic [31:0] v);
    req_valid <= 1;
    func <= f;
    bank <= b;
    reg_index <= n;
    write_data <= v;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic random_request();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = 32'h0;
      1: v = 32'hffff_ffff;
      2: v = 32'h1 << $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = $urandom;
    send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 5'($urandom_range(0, 31)), v);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset values, special registers, field extremes
    send_request(FUNC_READ, BANK_DATA, 31, 0);
    send_request(FUNC_WRITE, BANK_DATA, 30, 32'h0000_0000);
    send_request(FUNC_READ, BANK_DATA, 31, 0);
    send_request(FUNC_WRITE, BANK_DATA, 30, 32'hffff_ffff);
    send_request(FUNC_READ, BANK_DATA, 31, 0);
    send_request(FUNC_WRITE, BANK_DATA, 30, 32'h0000_8000);
    send_request(FUNC_READ, BANK_DATA, 31, 0);
    send_request(FUNC_WRITE, BANK_DATA, 15, 32'h1111_2222);
    send_request(FUNC_WRITE, BANK_DATA, 15, 32'h3333_4444);
    send_request(FUNC_WRITE, BANK_DATA, 15, 32'h5555_6666);
    send_request(FUNC_READ, BANK_DATA, 12, 0);
    send_request(FUNC_READ, BANK_DATA, 14, 0);
    send_request(FUNC_WRITE, BANK_DATA, 28, 32'hffff_7fff);
    send_request(FUNC_READ, BANK_DATA, 29, 0);
    send_request(FUNC_WRITE, BANK_DATA, 9, 32'h0000_8000);
    send_request(FUNC_WRITE, BANK_DATA, 10, 32'h0000_7fff);
    send_request(FUNC_READ, BANK_DATA, 28, 0);
    send_request(FUNC_WRITE, BANK_DATA, 29, 32'hffff_ffff);
    send_request(FUNC_WRITE, BANK_DATA, 31, 32'hffff_ffff);
    send_request(FUNC_READ, BANK_DATA, 31, 0);
    send_request(FUNC_WRITE, BANK_CTRL, 31, 32'h0000_2000);
    send_request(FUNC_READ, BANK_CTRL, 31, 0);
    send_request(FUNC_WRITE, BANK_CTRL, 26, 32'h0000_ffff);
    send_request(FUNC_READ, BANK_CTRL, 26, 0);
    // random bursts; one drain pause and one long receiver hold-off
    for (int i = 0; i < 2000; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) random_request();
      i += burst;
      if (i > 600 && !hold_done && !hold_off) hold_off = 1;
      if (i > 1200 && i - burst <= 1200) begin
        req_valid <= 0;
        @(posedge clk iff pending == 0);
      end else if ($urandom_range(0, 1)) begin
        req_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    req_valid <= 0;
    @(posedge clk iff pending == 0);
    repeat (10) @(posedge clk);
    $display("Covered %0d reads and %0d writes across both banks and all registers.",
             reads_seen, writes_seen);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
